// ----- hw/rtl/lav_pkg.sv -----
// shared types and constants for the look-at view matrix pipeline
// no dependencies; every other file imports this package
package lav_pkg;

    localparam int FRAC_BITS = 30;           // fraction bits of a unit vector component
    localparam int WORD_W    = 32;           // port words
    localparam int WIDE_W    = 64;           // exact products and sums
    localparam int DIFF_W    = WORD_W + 1;   // target minus eye
    localparam int NORM_W    = 31;           // aligned magnitude, msb at bit FRAC_BITS
    localparam int ROOT_W    = 32;           // length from the square root
    localparam int LANES     = 3;            // x, y, z

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic [NORM_W-1:0]        norm_t;
    typedef logic [ROOT_W-1:0]        root_t;

    localparam norm_t ONE_Q30 = norm_t'(1) << FRAC_BITS;

endpackage

// ----- hw/rtl/lav_isqrt.sv -----
// pipelined integer square root, one root bit per stage, with side payload
// depends on lav_pkg
module lav_isqrt
    import lav_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2*ROOT_W-1:0]   in_x,
    input  logic [PW-1:0]         in_pay,
    output logic                  out_valid,
    input  logic                  out_ready,
    output root_t                 out_root,
    output logic [PW-1:0]         out_pay
);

    localparam int NS = ROOT_W;
    localparam int RW = ROOT_W + 4;

    logic                 vld_reg  [NS];
    logic                 en       [NS+1];
    logic [2*ROOT_W-1:0]  x_reg    [NS];
    logic [RW-1:0]        rem_reg  [NS];
    root_t                root_reg [NS];
    logic [PW-1:0]        pay_reg  [NS];

    assign en[NS]    = out_ready;
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_pay   = pay_reg[NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                vld_prev;
        logic [2*ROOT_W-1:0] x_prev;
        logic [RW-1:0]       rem_prev;
        root_t               root_prev;
        logic [PW-1:0]       pay_prev;
        logic [RW-1:0]       acc;
        logic [RW-1:0]       trial;
        logic [RW-1:0]       rem_next;
        root_t               root_next;

        // stage advances when empty or when the next one advances
        assign en[k] = ~vld_reg[k] | en[k+1];

        if (k == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign x_prev    = in_x;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign pay_prev  = in_pay;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign x_prev    = x_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign pay_prev  = pay_reg[k-1];
        end

        // bring in two radicand bits, try root*4+1
        always_comb
        begin
            acc   = {rem_prev[RW-3:0], x_prev[2*(NS-1-k)+1 -: 2]};
            trial = RW'({root_prev, 2'b01});
            if (acc >= trial)
            begin
                rem_next  = acc - trial;
                root_next = {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = acc;
                root_next = {root_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                x_reg[k]    <= x_prev;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                pay_reg[k]  <= pay_prev;
            end
        end
    end

endmodule

// ----- hw/rtl/lav_div.sv -----
// pipelined three-lane rounded divider: a setup stage, then one quotient bit per stage
// computes floor((n * 2^30 + len/2) / len); depends on lav_pkg
module lav_div
    import lav_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LANES-1:0][NORM_W-1:0]  in_n,
    input  root_t                         in_len,
    input  logic [PW-1:0]                 in_pay,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LANES-1:0][NORM_W-1:0]  out_q,
    output logic [PW-1:0]                 out_pay
);

    localparam int NS = NORM_W + 1;
    localparam int DW = NORM_W + FRAC_BITS + 1;

    logic                          vld_reg [NS];
    logic                          en      [NS+1];
    logic [LANES-1:0][NORM_W-1:0]  low_reg [NS];
    logic [LANES-1:0][ROOT_W-1:0]  rem_reg [NS];
    logic [LANES-1:0][NORM_W-1:0]  q_reg   [NS];
    root_t                         len_reg [NS];
    logic [PW-1:0]                 pay_reg [NS];

    assign en[NS]    = out_ready;
    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign out_q     = q_reg[NS-1];
    assign out_pay   = pay_reg[NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                          vld_prev;
        root_t                         len_prev;
        logic [PW-1:0]                 pay_prev;
        logic [LANES-1:0][NORM_W-1:0]  low_next;
        logic [LANES-1:0][ROOT_W-1:0]  rem_next;
        logic [LANES-1:0][NORM_W-1:0]  q_next;

        assign en[k] = ~vld_reg[k] | en[k+1];

        if (k == 0)
        begin : g_setup
            logic [LANES-1:0][DW-1:0] num;

            assign vld_prev = in_valid;
            assign len_prev = in_len;
            assign pay_prev = in_pay;

            // dividend with half the divisor added, split into head and tail bits
            always_comb
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    num[i]      = {1'b0, in_n[i], {FRAC_BITS{1'b0}}} + DW'(in_len >> 1);
                    rem_next[i] = ROOT_W'(num[i][DW-1:NORM_W]);
                    low_next[i] = num[i][NORM_W-1:0];
                    q_next[i]   = '0;
                end
            end
        end
        else
        begin : g_step
            logic [LANES-1:0][ROOT_W:0] acc;

            assign vld_prev = vld_reg[k-1];
            assign len_prev = len_reg[k-1];
            assign pay_prev = pay_reg[k-1];

            // restoring step on the next dividend bit
            always_comb
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    acc[i]      = {rem_reg[k-1][i], low_reg[k-1][i][NORM_W-k]};
                    low_next[i] = low_reg[k-1][i];
                    if (acc[i] >= {1'b0, len_reg[k-1]})
                    begin
                        rem_next[i] = ROOT_W'(acc[i] - {1'b0, len_reg[k-1]});
                        q_next[i]   = {q_reg[k-1][i][NORM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = acc[i][ROOT_W-1:0];
                        q_next[i]   = {q_reg[k-1][i][NORM_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                low_reg[k] <= low_next;
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
                len_reg[k] <= len_prev;
                pay_reg[k] <= pay_prev;
            end
        end
    end

endmodule

// ----- hw/rtl/lav_norm.sv -----
// vector normalizer: align, sum of squares, square root, divide, sign
// depends on lav_pkg, lav_isqrt and lav_div
module lav_norm
    import lav_pkg::*;
#(
    parameter int IW = DIFF_W,
    parameter int PW = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LANES-1:0][IW-1:0]      in_v,
    input  logic [PW-1:0]                 in_pay,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LANES-1:0][WORD_W-1:0]  out_f,
    output logic [PW-1:0]                 out_pay
);

    localparam int PBW  = $clog2(IW);
    localparam int SQ_W = 2 * NORM_W;
    localparam int NPW  = LANES * NORM_W;
    localparam int DPW  = PW + 1 + LANES;
    localparam int SPW  = DPW + NPW;

    logic en_a, en_b, en_c, en_d, en_e, en_f;

    // stage a: magnitudes, signs and largest magnitude
    logic                       vld_a_reg;
    logic [LANES-1:0][IW-1:0]   mag_a_reg, mag_a_next;
    logic [LANES-1:0]           sgn_a_reg, sgn_a_next;
    logic [IW-1:0]              mx_a_reg, mx_a_next;
    logic [PW-1:0]              pay_a_reg;

    // stage b: position of the leading one
    logic                       vld_b_reg;
    logic [LANES-1:0][IW-1:0]   mag_b_reg;
    logic [LANES-1:0]           sgn_b_reg;
    logic [PBW-1:0]             pos_b_reg, pos_b_next;
    logic                       zero_b_reg, zero_b_next;
    logic [PW-1:0]              pay_b_reg;

    // stage c: aligned magnitudes
    logic                       vld_c_reg;
    logic [LANES-1:0][NORM_W-1:0] n_c_reg, n_c_next;
    logic [LANES-1:0]           sgn_c_reg;
    logic                       zero_c_reg;
    logic [PW-1:0]              pay_c_reg;

    // stage d: squares
    logic                       vld_d_reg;
    logic [LANES-1:0][SQ_W-1:0] sq_d_reg, sq_d_next;
    logic [LANES-1:0][NORM_W-1:0] n_d_reg;
    logic [LANES-1:0]           sgn_d_reg;
    logic                       zero_d_reg;
    logic [PW-1:0]              pay_d_reg;

    // stage e: sum of squares
    logic                       vld_e_reg;
    logic [2*ROOT_W-1:0]        sum_e_reg, sum_e_next;
    logic [LANES-1:0][NORM_W-1:0] n_e_reg;
    logic [LANES-1:0]           sgn_e_reg;
    logic                       zero_e_reg;
    logic [PW-1:0]              pay_e_reg;

    // root and divider links
    logic                       sq_ready, sq_valid, dv_ready, dv_valid;
    root_t                      sq_root;
    logic [SPW-1:0]             sq_pay;
    logic [LANES-1:0][NORM_W-1:0] dv_q;
    logic [DPW-1:0]             dv_pay;

    // stage f: signed result
    logic                       vld_f_reg;
    logic [LANES-1:0][WORD_W-1:0] f_reg, f_next;
    logic [PW-1:0]              pay_f_reg;

    assign en_f     = ~vld_f_reg | out_ready;
    assign en_e     = ~vld_e_reg | sq_ready;
    assign en_d     = ~vld_d_reg | en_e;
    assign en_c     = ~vld_c_reg | en_d;
    assign en_b     = ~vld_b_reg | en_c;
    assign en_a     = ~vld_a_reg | en_b;
    assign in_ready = en_a;

    // magnitudes and max
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sgn_a_next[i] = in_v[i][IW-1];
            mag_a_next[i] = in_v[i][IW-1] ? (~in_v[i] + 1'b1) : in_v[i];
        end
        mx_a_next = mag_a_next[0];
        if (mag_a_next[1] > mx_a_next)
        begin
            mx_a_next = mag_a_next[1];
        end
        if (mag_a_next[2] > mx_a_next)
        begin
            mx_a_next = mag_a_next[2];
        end
    end

    // leading one search
    always_comb
    begin
        pos_b_next = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (mx_a_reg[i])
            begin
                pos_b_next = PBW'(i);
            end
        end
        zero_b_next = (mx_a_reg == '0);
    end

    // common shift so the largest lands in [2^30, 2^31)
    always_comb
    begin
        logic [IW-1:0] sh;
        for (int i = 0; i < LANES; i++)
        begin
            if (pos_b_reg >= PBW'(FRAC_BITS))
            begin
                sh = mag_b_reg[i] >> (pos_b_reg - PBW'(FRAC_BITS));
            end
            else
            begin
                sh = mag_b_reg[i] << (PBW'(FRAC_BITS) - pos_b_reg);
            end
            n_c_next[i] = sh[NORM_W-1:0];
        end
    end

    // squares
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sq_d_next[i] = n_c_reg[i] * n_c_reg[i];
        end
    end

    // sum
    assign sum_e_next = (2*ROOT_W)'(sq_d_reg[0]) + (2*ROOT_W)'(sq_d_reg[1])
                      + (2*ROOT_W)'(sq_d_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                vld_a_reg <= in_valid;
            end
            if (en_b)
            begin
                vld_b_reg <= vld_a_reg;
            end
            if (en_c)
            begin
                vld_c_reg <= vld_b_reg;
            end
            if (en_d)
            begin
                vld_d_reg <= vld_c_reg;
            end
            if (en_e)
            begin
                vld_e_reg <= vld_d_reg;
            end
            if (en_f)
            begin
                vld_f_reg <= dv_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mag_a_reg <= mag_a_next;
            sgn_a_reg <= sgn_a_next;
            mx_a_reg  <= mx_a_next;
            pay_a_reg <= in_pay;
        end
        if (en_b)
        begin
            mag_b_reg  <= mag_a_reg;
            sgn_b_reg  <= sgn_a_reg;
            pos_b_reg  <= pos_b_next;
            zero_b_reg <= zero_b_next;
            pay_b_reg  <= pay_a_reg;
        end
        if (en_c)
        begin
            n_c_reg    <= n_c_next;
            sgn_c_reg  <= sgn_b_reg;
            zero_c_reg <= zero_b_reg;
            pay_c_reg  <= pay_b_reg;
        end
        if (en_d)
        begin
            sq_d_reg   <= sq_d_next;
            n_d_reg    <= n_c_reg;
            sgn_d_reg  <= sgn_c_reg;
            zero_d_reg <= zero_c_reg;
            pay_d_reg  <= pay_c_reg;
        end
        if (en_e)
        begin
            sum_e_reg  <= sum_e_next;
            n_e_reg    <= n_d_reg;
            sgn_e_reg  <= sgn_d_reg;
            zero_e_reg <= zero_d_reg;
            pay_e_reg  <= pay_d_reg;
        end
        if (en_f)
        begin
            f_reg     <= f_next;
            pay_f_reg <= dv_pay[DPW-1:LANES+1];
        end
    end

    // vector length
    lav_isqrt #(
        .PW (SPW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_e_reg),
        .in_ready  (sq_ready),
        .in_x      (sum_e_reg),
        .in_pay    ({pay_e_reg, zero_e_reg, sgn_e_reg, n_e_reg}),
        .out_valid (sq_valid),
        .out_ready (dv_ready),
        .out_root  (sq_root),
        .out_pay   (sq_pay)
    );

    // component over length
    lav_div #(
        .PW (DPW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (dv_ready),
        .in_n      (sq_pay[NPW-1:0]),
        .in_len    (sq_root),
        .in_pay    (sq_pay[SPW-1:NPW]),
        .out_valid (dv_valid),
        .out_ready (en_f),
        .out_q     (dv_q),
        .out_pay   (dv_pay)
    );

    // clamp, zero vector, sign
    always_comb
    begin
        norm_t q;
        logic [WORD_W-1:0] qw;
        for (int i = 0; i < LANES; i++)
        begin
            q = (dv_q[i] > ONE_Q30) ? ONE_Q30 : dv_q[i];
            if (dv_pay[LANES])
            begin
                q = '0;
            end
            qw        = WORD_W'(q);
            f_next[i] = dv_pay[i] ? (~qw + 1'b1) : qw;
        end
    end

    assign out_valid = vld_f_reg;
    assign out_f     = f_reg;
    assign out_pay   = pay_f_reg;

endmodule

// ----- hw/rtl/lav_cross.sv -----
// exact cross product of two signed 32-bit vectors in two stages
// depends on lav_pkg
module lav_cross
    import lav_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [LANES-1:0][WORD_W-1:0]  in_a,
    input  logic [LANES-1:0][WORD_W-1:0]  in_b,
    input  logic [PW-1:0]                 in_pay,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LANES-1:0][WIDE_W-1:0]  out_c,
    output logic [PW-1:0]                 out_pay
);

    localparam int NP = 2 * LANES;

    logic en_1, en_2;
    logic vld_1_reg, vld_2_reg;
    logic [NP-1:0][WIDE_W-1:0]    prod_1_reg, prod_1_next;
    logic [PW-1:0]                pay_1_reg, pay_2_reg;
    logic [LANES-1:0][WIDE_W-1:0] c_2_reg, c_2_next;

    assign en_2     = ~vld_2_reg | out_ready;
    assign en_1     = ~vld_1_reg | en_2;
    assign in_ready = en_1;

    // six partial products
    always_comb
    begin
        word_t a0, a1, a2, b0, b1, b2;
        wide_t p0, p1, p2, p3, p4, p5;
        a0 = in_a[0];
        a1 = in_a[1];
        a2 = in_a[2];
        b0 = in_b[0];
        b1 = in_b[1];
        b2 = in_b[2];
        p0 = a1 * b2;
        p1 = a2 * b1;
        p2 = a2 * b0;
        p3 = a0 * b2;
        p4 = a0 * b1;
        p5 = a1 * b0;
        prod_1_next = {p5, p4, p3, p2, p1, p0};
    end

    // differences
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            c_2_next[i] = prod_1_reg[2*i] - prod_1_reg[2*i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_1_reg <= 1'b0;
            vld_2_reg <= 1'b0;
        end
        else
        begin
            if (en_1)
            begin
                vld_1_reg <= in_valid;
            end
            if (en_2)
            begin
                vld_2_reg <= vld_1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_1)
        begin
            prod_1_reg <= prod_1_next;
            pay_1_reg  <= in_pay;
        end
        if (en_2)
        begin
            c_2_reg   <= c_2_next;
            pay_2_reg <= pay_1_reg;
        end
    end

    assign out_valid = vld_2_reg;
    assign out_c     = c_2_reg;
    assign out_pay   = pay_2_reg;

endmodule

// ----- hw/rtl/lav_rows.sv -----
// final rows: rounds the up row, negates forward, forms the three offsets
// depends on lav_pkg
module lav_rows
    import lav_pkg::*;
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [LANES-1:0][WORD_W-1:0]              in_s,
    input  logic [LANES-1:0][WORD_W-1:0]              in_f,
    input  logic [LANES-1:0][WIDE_W-1:0]              in_cu,
    input  logic [LANES-1:0][WORD_W-1:0]              in_eye,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [LANES-1:0][LANES-1:0][WORD_W-1:0]   out_rot,
    output logic [LANES-1:0][WORD_W-1:0]              out_off
);

    localparam wide_t UNIT   = wide_t'(ONE_Q30);
    localparam wide_t SAT_HI = (wide_t'(1) <<< (WORD_W - 1)) - 1;
    localparam wide_t SAT_LO = -(wide_t'(1) <<< (WORD_W - 1));

    typedef logic [LANES-1:0][LANES-1:0][WORD_W-1:0] rot_t;

    // shift right by the fraction width, half away from zero
    function automatic wide_t round_q30(input wide_t v);
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] q;
        mag = v[WIDE_W-1] ? WIDE_W'(~v + 1'b1) : WIDE_W'(v);
        q   = (mag + (WIDE_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[WIDE_W-1] ? -wide_t'(q) : wide_t'(q);
    endfunction

    logic en_1, en_2, en_3, en_4;
    logic vld_1_reg, vld_2_reg, vld_3_reg, vld_4_reg;
    rot_t rot_1_reg, rot_1_next, rot_2_reg, rot_3_reg, rot_4_reg;
    logic [LANES-1:0][WORD_W-1:0] eye_1_reg;
    logic [LANES-1:0][LANES-1:0][WIDE_W-1:0] prod_2_reg, prod_2_next;
    logic [LANES-1:0][WIDE_W-1:0] acc_3_reg, acc_3_next;
    logic [LANES-1:0][WORD_W-1:0] off_4_reg, off_4_next;

    assign en_4     = ~vld_4_reg | out_ready;
    assign en_3     = ~vld_3_reg | en_4;
    assign en_2     = ~vld_2_reg | en_3;
    assign en_1     = ~vld_1_reg | en_2;
    assign in_ready = en_1;

    // rotation rows: side, rounded up, negated forward
    always_comb
    begin
        wide_t r;
        for (int i = 0; i < LANES; i++)
        begin
            r = round_q30(wide_t'(in_cu[i]));
            if (r > UNIT)
            begin
                r = UNIT;
            end
            else if (r < -UNIT)
            begin
                r = -UNIT;
            end
            rot_1_next[0][i] = in_s[i];
            rot_1_next[1][i] = r[WORD_W-1:0];
            rot_1_next[2][i] = ~in_f[i] + 1'b1;
        end
    end

    // row times eye products
    always_comb
    begin
        word_t a, b;
        wide_t p;
        for (int j = 0; j < LANES; j++)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                a = rot_1_reg[j][i];
                b = eye_1_reg[i];
                p = a * b;
                prod_2_next[j][i] = p;
            end
        end
    end

    // dot sums
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            acc_3_next[j] = prod_2_reg[j][0] + prod_2_reg[j][1] + prod_2_reg[j][2];
        end
    end

    // round and saturate offsets
    always_comb
    begin
        wide_t r;
        for (int j = 0; j < LANES; j++)
        begin
            r = round_q30(wide_t'(acc_3_reg[j]));
            if (r > SAT_HI)
            begin
                r = SAT_HI;
            end
            else if (r < SAT_LO)
            begin
                r = SAT_LO;
            end
            off_4_next[j] = r[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_1_reg <= 1'b0;
            vld_2_reg <= 1'b0;
            vld_3_reg <= 1'b0;
            vld_4_reg <= 1'b0;
        end
        else
        begin
            if (en_1)
            begin
                vld_1_reg <= in_valid;
            end
            if (en_2)
            begin
                vld_2_reg <= vld_1_reg;
            end
            if (en_3)
            begin
                vld_3_reg <= vld_2_reg;
            end
            if (en_4)
            begin
                vld_4_reg <= vld_3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_1)
        begin
            rot_1_reg <= rot_1_next;
            eye_1_reg <= in_eye;
        end
        if (en_2)
        begin
            rot_2_reg   <= rot_1_reg;
            prod_2_reg  <= prod_2_next;
        end
        if (en_3)
        begin
            rot_3_reg <= rot_2_reg;
            acc_3_reg <= acc_3_next;
        end
        if (en_4)
        begin
            rot_4_reg <= rot_3_reg;
            off_4_reg <= off_4_next;
        end
    end

    assign out_valid = vld_4_reg;
    assign out_rot   = rot_4_reg;
    assign out_off   = off_4_reg;

endmodule

// ----- hw/rtl/look_at_view_matrix.sv -----
// Look-at view matrix: takes eye, target and up in signed Q16.16 and returns the top three
// rows of the view matrix, rotation in Q2.30 and offsets in saturated Q16.16. It keeps no state
// between items and takes one item every clock while the output is not stalled. Most of the
// pipe lies in the two normalizers, each running a 32-stage square root (one root bit per
// stage) and a 32-stage divider (a setup stage, then one quotient bit per stage).
// A stall at the output only fills empty stages: items keep entering until the pipe is full.
// depends on lav_pkg, lav_norm, lav_cross and lav_rows
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [31:0]  eye_x,
    input  logic [31:0]  eye_y,
    input  logic [31:0]  eye_z,
    input  logic [31:0]  target_x,
    input  logic [31:0]  target_y,
    input  logic [31:0]  target_z,
    input  logic [31:0]  up_x,
    input  logic [31:0]  up_y,
    input  logic [31:0]  up_z,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  side_x,
    output logic [31:0]  side_y,
    output logic [31:0]  side_z,
    output logic [31:0]  side_offset,
    output logic [31:0]  upv_x,
    output logic [31:0]  upv_y,
    output logic [31:0]  upv_z,
    output logic [31:0]  upv_offset,
    output logic [31:0]  back_x,
    output logic [31:0]  back_y,
    output logic [31:0]  back_z,
    output logic [31:0]  back_offset
);

    localparam int VW = LANES * WORD_W;

    logic [LANES-1:0][WORD_W-1:0] eye_v, tgt_v, up_v;
    logic [LANES-1:0][DIFF_W-1:0] dir_v;

    logic n1_ready, n1_valid, c1_ready, c1_valid;
    logic n2_ready, n2_valid, c2_ready, c2_valid, rw_ready;
    logic [LANES-1:0][WORD_W-1:0] fwd_v, side_v;
    logic [LANES-1:0][WIDE_W-1:0] c1_v, c2_v;
    logic [2*VW-1:0] n1_pay, c1_pay, n2_pay;
    logic [3*VW-1:0] c2_pay;
    logic [LANES-1:0][LANES-1:0][WORD_W-1:0] rot;
    logic [LANES-1:0][WORD_W-1:0] off;

    assign eye_v = {eye_z, eye_y, eye_x};
    assign tgt_v = {target_z, target_y, target_x};
    assign up_v  = {up_z, up_y, up_x};

    // exact view direction
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            dir_v[i] = {tgt_v[i][WORD_W-1], tgt_v[i]} - {eye_v[i][WORD_W-1], eye_v[i]};
        end
    end

    // forward
    lav_norm #(
        .IW (DIFF_W),
        .PW (2*VW)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (n1_ready),
        .in_v      (dir_v),
        .in_pay    ({up_v, eye_v}),
        .out_valid (n1_valid),
        .out_ready (c1_ready),
        .out_f     (fwd_v),
        .out_pay   (n1_pay)
    );

    assign in_ready = n1_ready;

    // forward cross up
    lav_cross #(
        .PW (2*VW)
    ) u_cross_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n1_valid),
        .in_ready  (c1_ready),
        .in_a      (fwd_v),
        .in_b      (n1_pay[2*VW-1:VW]),
        .in_pay    ({fwd_v, n1_pay[VW-1:0]}),
        .out_valid (c1_valid),
        .out_ready (n2_ready),
        .out_c     (c1_v),
        .out_pay   (c1_pay)
    );

    // side
    lav_norm #(
        .IW (WIDE_W),
        .PW (2*VW)
    ) u_norm_side (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c1_valid),
        .in_ready  (n2_ready),
        .in_v      (c1_v),
        .in_pay    (c1_pay),
        .out_valid (n2_valid),
        .out_ready (c2_ready),
        .out_f     (side_v),
        .out_pay   (n2_pay)
    );

    // side cross forward
    lav_cross #(
        .PW (3*VW)
    ) u_cross_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (n2_valid),
        .in_ready  (c2_ready),
        .in_a      (side_v),
        .in_b      (n2_pay[2*VW-1:VW]),
        .in_pay    ({side_v, n2_pay}),
        .out_valid (c2_valid),
        .out_ready (rw_ready),
        .out_c     (c2_v),
        .out_pay   (c2_pay)
    );

    // rows and offsets, ends in the output register
    lav_rows u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c2_valid),
        .in_ready  (rw_ready),
        .in_s      (c2_pay[3*VW-1:2*VW]),
        .in_f      (c2_pay[2*VW-1:VW]),
        .in_cu     (c2_v),
        .in_eye    (c2_pay[VW-1:0]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rot   (rot),
        .out_off   (off)
    );

    assign side_x      = rot[0][0];
    assign side_y      = rot[0][1];
    assign side_z      = rot[0][2];
    assign side_offset = off[0];
    assign upv_x       = rot[1][0];
    assign upv_y       = rot[1][1];
    assign upv_z       = rot[1][2];
    assign upv_offset  = off[1];
    assign back_x      = rot[2][0];
    assign back_y      = rot[2][1];
    assign back_z      = rot[2][2];
    assign back_offset = off[2];

endmodule
